### rtl/core/sip_pkg.sv
// Shared types and constants for the self-boot image parser.
// Used by the front parser, the result queue, the back end and the top level.
package sip_pkg;

    localparam logic [6:0] DEV_ADDR_RESET = 7'd52;
    localparam int         QUEUE_DEPTH_DEFAULT = 4;
    localparam logic [15:0] MIN_BLOCK_LEN = 16'd3;

    localparam logic [7:0] OP_END   = 8'h00;
    localparam logic [7:0] OP_WRITE = 8'h01;
    localparam logic [7:0] OP_DELAY = 8'h02;
    localparam logic [7:0] OP_NOP_A = 8'h03;
    localparam logic [7:0] OP_NOP_B = 8'h04;
    localparam logic [7:0] OP_NOP_C = 8'h05;
    localparam logic [7:0] OP_END_B = 8'h06;

    localparam logic CMD_BYTE  = 1'b0;
    localparam logic CMD_FAULT = 1'b1;

    typedef enum logic [2:0] {
        K_WRITE     = 3'd0,
        K_ADDR_ONLY = 3'd1,
        K_DELAY     = 3'd2,
        K_DONE      = 3'd3,
        K_ERROR     = 3'd4
    } t_kind;

    typedef enum logic [3:0] {
        PH_OPCODE  = 4'd0,
        PH_LEN_HI  = 4'd1,
        PH_LEN_LO  = 4'd2,
        PH_SKIP    = 4'd3,
        PH_ADDR_HI = 4'd4,
        PH_ADDR_LO = 4'd5,
        PH_DATA    = 4'd6,
        PH_DLY_HI  = 4'd7,
        PH_DLY_LO  = 4'd8
    } t_phase;

    typedef struct packed {
        t_kind       kind;
        logic [6:0]  bus_target;
        logic [15:0] reg_address;
        logic [7:0]  data_byte;
        logic        block_first;
        logic        block_last;
        logic [15:0] delay_value;
        logic        trunc_error;
    } t_entry;

endpackage

### rtl/core/sip_front.sv
// Front parser: accepts image bytes and bus faults, tracks the record state
// and classifies each item into at most one queue entry. Depends on sip_pkg.
module sip_front
    import sip_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_accept,
    input  logic        i_command,
    input  logic [7:0]  i_image_byte,
    input  logic        i_image_last,
    input  logic        i_cfg_write,
    input  logic [6:0]  i_cfg_data,
    output logic        o_push,
    output t_entry      o_entry
);

    t_phase      r_phase, n_phase;
    logic [15:0] r_block_length, n_block_length;
    logic [15:0] r_body_count, n_body_count;
    logic [15:0] r_block_reg, n_block_reg;
    logic [7:0]  r_delay_high, n_delay_high;
    logic        r_finished, n_finished;
    logic [6:0]  r_dev_addr;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase        <= PH_OPCODE;
            r_block_length <= '0;
            r_body_count   <= '0;
            r_block_reg    <= '0;
            r_delay_high   <= '0;
            r_finished     <= 1'b0;
            r_dev_addr     <= DEV_ADDR_RESET;
        end else begin
            r_phase        <= n_phase;
            r_block_length <= n_block_length;
            r_body_count   <= n_body_count;
            r_block_reg    <= n_block_reg;
            r_delay_high   <= n_delay_high;
            r_finished     <= n_finished;
            if (i_cfg_write) begin
                r_dev_addr <= i_cfg_data;
            end
        end
    end

    always_comb begin
        logic        has_res;
        logic        ended;
        logic        two;
        t_kind       kind0;
        logic [7:0]  data0;
        logic        first0;
        logic        last0;
        logic [15:0] dly0;
        logic [15:0] reg0;
        logic [15:0] cnt1;
        logic        wr;

        n_phase        = r_phase;
        n_block_length = r_block_length;
        n_body_count   = r_body_count;
        n_block_reg    = r_block_reg;
        n_delay_high   = r_delay_high;
        n_finished     = r_finished;
        has_res = 1'b0;
        ended   = 1'b0;
        two     = 1'b0;
        kind0   = K_ERROR;
        data0   = '0;
        first0  = 1'b0;
        last0   = 1'b0;
        dly0    = '0;
        reg0    = r_block_reg;
        cnt1    = r_body_count + 16'd1;

        if (i_accept) begin
            if (i_command == CMD_FAULT) begin
                if (!r_finished) begin
                    has_res    = 1'b1;
                    kind0      = K_ERROR;
                    n_finished = 1'b1;
                end
            end else if (r_finished) begin
                if (i_image_last) begin
                    n_phase        = PH_OPCODE;
                    n_block_length = '0;
                    n_body_count   = '0;
                    n_block_reg    = '0;
                    n_delay_high   = '0;
                    n_finished     = 1'b0;
                end
            end else begin
                unique case (r_phase)
                    PH_OPCODE: begin
                        unique case (i_image_byte) inside
                            OP_END, OP_END_B: begin
                                has_res = 1'b1;
                                kind0   = K_DONE;
                                ended   = 1'b1;
                            end
                            OP_WRITE: n_phase = PH_LEN_HI;
                            OP_DELAY: n_phase = PH_DLY_HI;
                            OP_NOP_A, OP_NOP_B, OP_NOP_C: n_phase = PH_OPCODE;
                            default: begin
                                has_res = 1'b1;
                                kind0   = K_ERROR;
                                ended   = 1'b1;
                            end
                        endcase
                    end
                    PH_LEN_HI: begin
                        n_block_length = {i_image_byte, 8'h00};
                        n_phase        = PH_LEN_LO;
                    end
                    PH_LEN_LO: begin
                        n_block_length = {r_block_length[15:8], i_image_byte};
                        if (n_block_length < MIN_BLOCK_LEN) begin
                            has_res = 1'b1;
                            kind0   = K_ERROR;
                            ended   = 1'b1;
                        end else begin
                            n_phase = PH_SKIP;
                        end
                    end
                    PH_SKIP: n_phase = PH_ADDR_HI;
                    PH_ADDR_HI: begin
                        n_block_reg = {i_image_byte, 8'h00};
                        n_phase     = PH_ADDR_LO;
                    end
                    PH_ADDR_LO: begin
                        n_block_reg  = {r_block_reg[15:8], i_image_byte};
                        reg0         = n_block_reg;
                        n_body_count = '0;
                        if (r_block_length == MIN_BLOCK_LEN) begin
                            has_res = 1'b1;
                            kind0   = K_ADDR_ONLY;
                            first0  = 1'b1;
                            last0   = 1'b1;
                            n_phase = PH_OPCODE;
                        end else begin
                            n_phase = PH_DATA;
                        end
                    end
                    PH_DATA: begin
                        has_res      = 1'b1;
                        kind0        = K_WRITE;
                        data0        = i_image_byte;
                        first0       = (r_body_count == 16'd0);
                        n_body_count = cnt1;
                        last0        = (cnt1 == (r_block_length - MIN_BLOCK_LEN));
                        if (last0) begin
                            n_phase = PH_OPCODE;
                        end
                    end
                    PH_DLY_HI: begin
                        n_delay_high = i_image_byte;
                        n_phase      = PH_DLY_LO;
                    end
                    PH_DLY_LO: begin
                        has_res = 1'b1;
                        kind0   = K_DELAY;
                        dly0    = {r_delay_high, i_image_byte};
                        n_phase = PH_OPCODE;
                    end
                    default: n_phase = PH_OPCODE;
                endcase

                if (i_image_last) begin
                    if (!ended) begin
                        if (has_res) begin
                            two = 1'b1;
                        end else begin
                            has_res = 1'b1;
                            kind0   = K_ERROR;
                        end
                    end
                    n_phase        = PH_OPCODE;
                    n_block_length = '0;
                    n_body_count   = '0;
                    n_block_reg    = '0;
                    n_delay_high   = '0;
                    n_finished     = 1'b0;
                end else if (ended) begin
                    n_finished = 1'b1;
                end
            end
        end

        wr = (kind0 == K_WRITE) || (kind0 == K_ADDR_ONLY);
        o_push              = has_res;
        o_entry.kind        = kind0;
        o_entry.bus_target  = wr ? r_dev_addr : 7'd0;
        o_entry.reg_address = wr ? reg0 : 16'd0;
        o_entry.data_byte   = (kind0 == K_WRITE) ? data0 : 8'd0;
        o_entry.block_first = wr ? first0 : 1'b0;
        o_entry.block_last  = wr ? last0 : 1'b0;
        o_entry.delay_value = (kind0 == K_DELAY) ? dly0 : 16'd0;
        o_entry.trunc_error = two;
    end

endmodule

### rtl/core/sip_queue.sv
// Short first-in first-out queue of classified entries between front and back.
// Depends on sip_pkg for the entry type.
module sip_queue
    import sip_pkg::*;
#(
    parameter int DEPTH = QUEUE_DEPTH_DEFAULT
) (
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  logic   i_push,
    input  t_entry i_entry,
    input  logic   i_pop,
    output logic   o_full,
    output logic   o_empty,
    output t_entry o_head
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [PW-1:0] LAST_PTR = PW'(DEPTH - 1);
    localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

    t_entry        r_mem [DEPTH];
    logic [PW-1:0] r_wr_ptr, n_wr_ptr;
    logic [PW-1:0] r_rd_ptr, n_rd_ptr;
    logic [CW-1:0] r_count, n_count;
    logic          do_push, do_pop;

    assign o_full  = (r_count == FULL_CNT);
    assign o_empty = (r_count == '0);
    assign o_head  = r_mem[r_rd_ptr];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (do_push) begin
            n_wr_ptr = (r_wr_ptr == LAST_PTR) ? '0 : r_wr_ptr + 1'b1;
        end
        if (do_pop) begin
            n_rd_ptr = (r_rd_ptr == LAST_PTR) ? '0 : r_rd_ptr + 1'b1;
        end
        if (do_push && !do_pop) begin
            n_count = r_count + 1'b1;
        end else if (do_pop && !do_push) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_entry;
        end
    end

endmodule

### rtl/core/sip_back.sv
// Back end: takes queue entries and drives the registered result channel,
// adding the trailing truncation error where an entry carries one. Uses sip_pkg.
module sip_back
    import sip_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_empty,
    input  t_entry      i_head,
    output logic        o_pop,
    output logic        o_valid,
    input  logic        i_ready,
    output t_entry      o_result,
    output logic        o_run_last
);

    logic   r_valid, n_valid;
    logic   r_pend, n_pend;
    t_entry r_res, n_res;
    logic   r_run_last, n_run_last;
    logic   slot_free;

    assign slot_free  = !r_valid || i_ready;
    assign o_valid    = r_valid;
    assign o_result   = r_res;
    assign o_run_last = r_run_last;

    always_comb begin
        n_valid    = r_valid;
        n_pend     = r_pend;
        n_res      = r_res;
        n_run_last = r_run_last;
        o_pop      = 1'b0;
        if (slot_free) begin
            if (r_pend) begin
                n_valid    = 1'b1;
                n_pend     = 1'b0;
                n_res      = '0;
                n_res.kind = K_ERROR;
                n_run_last = 1'b1;
            end else if (!i_empty) begin
                o_pop      = 1'b1;
                n_valid    = 1'b1;
                n_res      = i_head;
                n_pend     = i_head.trunc_error;
                n_run_last = !i_head.trunc_error;
            end else begin
                n_valid = 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_pend  <= 1'b0;
        end else begin
            r_valid <= n_valid;
            r_pend  <= n_pend;
        end
        r_res      <= n_res;
        r_run_last <= n_run_last;
    end

endmodule

### rtl/core/selfboot_image_parser_unit.sv
// A result is written into the queue and then into the registered output stage of
// the back end before it is presented.
// Throughput: one input item per cycle while the queue is not full; the output
// registers one result per cycle while ready, so a write with a truncation error gives two results.
// Queue depth sets how far the front may run ahead of a stalled output.
// Reset is synchronous and active low; the device address returns to 52.
module selfboot_image_parser_unit
    import sip_pkg::*;
#(
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEFAULT
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic        i_command,
    input  logic [7:0]  i_image_byte,
    input  logic        i_image_last,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [2:0]  o_kind,
    output logic [6:0]  o_bus_target,
    output logic [15:0] o_reg_address,
    output logic [7:0]  o_data_byte,
    output logic        o_block_first,
    output logic        o_block_last,
    output logic [15:0] o_delay_value,
    output logic        o_run_last,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [6:0]  i_cfg_data
);

    logic   full, empty, push, pop, accept;
    t_entry push_entry, head, result;

    assign o_in_ready  = !full;
    assign accept      = i_in_valid && !full;
    assign o_cfg_ready = 1'b1;

    sip_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_accept     (accept),
        .i_command    (i_command),
        .i_image_byte (i_image_byte),
        .i_image_last (i_image_last),
        .i_cfg_write  (i_cfg_valid),
        .i_cfg_data   (i_cfg_data),
        .o_push       (push),
        .o_entry      (push_entry)
    );

    sip_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_entry (push_entry),
        .i_pop   (pop),
        .o_full  (full),
        .o_empty (empty),
        .o_head  (head)
    );

    sip_back u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_empty    (empty),
        .i_head     (head),
        .o_pop      (pop),
        .o_valid    (o_out_valid),
        .i_ready    (i_out_ready),
        .o_result   (result),
        .o_run_last (o_run_last)
    );

    assign o_kind        = result.kind;
    assign o_bus_target  = result.bus_target;
    assign o_reg_address = result.reg_address;
    assign o_data_byte   = result.data_byte;
    assign o_block_first = result.block_first;
    assign o_block_last  = result.block_last;
    assign o_delay_value = result.delay_value;

endmodule

### rtl/core/sip_checker.sv
// Port-level checks for the self-boot image parser, bound to the top level.
// Depends on sip_pkg for the result kind codes.
module sip_checker
    import sip_pkg::*;
(
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_out_valid,
    input logic        i_out_ready,
    input logic [2:0]  o_kind,
    input logic [6:0]  o_bus_target,
    input logic [15:0] o_reg_address,
    input logic [7:0]  o_data_byte,
    input logic        o_block_first,
    input logic        o_block_last,
    input logic [15:0] o_delay_value,
    input logic        o_run_last
);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_kind)
            && $stable(o_data_byte) && $stable(o_run_last))
        else $error("result changed while stalled");

    a_done_final: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_kind == K_DONE) |-> o_run_last)
        else $error("done result is not the last of its item");

    a_status_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && ((o_kind == K_DONE) || (o_kind == K_ERROR)) |->
            (o_bus_target == 7'd0) && (o_reg_address == 16'd0) && (o_data_byte == 8'd0)
            && !o_block_first && !o_block_last && (o_delay_value == 16'd0))
        else $error("status result carries payload");

    a_addr_only: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_kind == K_ADDR_ONLY) |->
            o_block_first && o_block_last && (o_data_byte == 8'd0))
        else $error("address-only write is malformed");

endmodule

bind selfboot_image_parser_unit sip_checker u_sip_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .o_out_valid   (o_out_valid),
    .i_out_ready   (i_out_ready),
    .o_kind        (o_kind),
    .o_bus_target  (o_bus_target),
    .o_reg_address (o_reg_address),
    .o_data_byte   (o_data_byte),
    .o_block_first (o_block_first),
    .o_block_last  (o_block_last),
    .o_delay_value (o_delay_value),
    .o_run_last    (o_run_last)
);
